// ----- rtl/custom_alphabet_sort_check_macros.svh -----
// ----------------------------------------------------------------------------
// Custom alphabet sort check: assertion macros
// Shared property shorthands for the clocked checks of the block.
// ----------------------------------------------------------------------------
`ifndef CUSTOM_ALPHABET_SORT_CHECK_MACROS_SVH
`define CUSTOM_ALPHABET_SORT_CHECK_MACROS_SVH

// same-cycle implication, disabled in reset
`define CAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define CAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/cas_pkg.sv -----
// ----------------------------------------------------------------------------
// Custom alphabet sort check: package
// Widths, register map, reset values and the front-to-back command type.
// ----------------------------------------------------------------------------
`default_nettype none

package cas_pkg;

  localparam int LETTER_W  = 5;
  localparam int RANK_W    = 5;
  localparam int POS_W     = 6;
  localparam int LETTERS   = 26;
  localparam int TABLE_W   = LETTERS * RANK_W;

  localparam logic [POS_W-1:0]  POS_MAX   = 6'd63;
  localparam logic [RANK_W-1:0] RANK_NONE = 5'd31;

  localparam int MAX_WORD_LEN_DEFAULT = 32;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 64;
  localparam int LOW_W      = 60;
  localparam int MID_W      = 60;
  localparam int HIGH_W     = 10;

  localparam logic [1:0] REG_RANK_LOW  = 2'd0;
  localparam logic [1:0] REG_RANK_MID  = 2'd1;
  localparam logic [1:0] REG_RANK_HIGH = 2'd2;

  localparam logic [LOW_W-1:0]  RANK_LOW_RESET  = 60'd407901468851701792;
  localparam logic [MID_W-1:0]  RANK_MID_RESET  = 60'd854193664183384492;
  localparam logic [HIGH_W-1:0] RANK_HIGH_RESET = 10'd824;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [RANK_W-1:0] prev_rank;
    logic              in_range;    // previous word has a letter here
    logic              have_prev;
    logic              short_word;  // word ends before previous one did
    logic              overflow;
    logic              word_end;    // includes list end
    logic              list_end;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/cas_front.sv -----
// ----------------------------------------------------------------------------
// Custom alphabet sort check: front end
// Ranks each letter, tracks position and previous word length, keeps the
// previous word's ranks in a buffer and issues one command per letter.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_front import cas_pkg::*; #(
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [LETTER_W-1:0] letter,
  input  logic                word_end,
  input  logic                list_end,
  input  logic [TABLE_W-1:0]  rank_table,
  output logic                cmd_valid,
  output cmd_t                cmd
);

  localparam int AW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_WORD_LEN);

  function automatic logic [RANK_W-1:0] rank_of(input logic [LETTER_W-1:0] code,
                                                input logic [TABLE_W-1:0] tbl);
    logic [RANK_W-1:0] r;
    r = RANK_NONE;
    if (code < LETTER_W'(LETTERS)) begin
      r = tbl[RANK_W*code +: RANK_W];
    end
    return r;
  endfunction

  logic [RANK_W-1:0] buf_mem [MAX_WORD_LEN];

  logic [POS_W-1:0] position;
  logic [POS_W-1:0] previous_length;
  logic             have_previous;

  logic              wend;
  logic              in_buf;
  logic [POS_W-1:0]  cur_len;
  logic [RANK_W-1:0] rank;
  logic [AW-1:0]     addr;

  assign wend    = word_end | list_end;
  assign in_buf  = position < MAX_POS;
  assign cur_len = (position < POS_MAX) ? position + POS_W'(1) : POS_MAX;
  assign rank    = rank_of(letter, rank_table);
  assign addr    = position[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= '0;
      previous_length <= '0;
      have_previous   <= 1'b0;
      cmd_valid       <= 1'b0;
    end else begin
      cmd_valid <= accept;
      if (accept) begin
        if (list_end) begin
          position        <= '0;
          previous_length <= '0;
          have_previous   <= 1'b0;
        end else if (wend) begin
          previous_length <= (cur_len < MAX_POS) ? cur_len : MAX_POS;
          have_previous   <= 1'b1;
          position        <= '0;
        end else begin
          position <= cur_len;
        end
      end
    end
  end

  // read-first: the command carries the previous word's rank at this position
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_buf) begin
        buf_mem[addr] <= rank;
      end
      cmd.prev_rank  <= buf_mem[addr];
      cmd.rank       <= rank;
      cmd.in_range   <= in_buf && (position < previous_length);
      cmd.have_prev  <= have_previous;
      cmd.short_word <= cur_len < previous_length;
      cmd.overflow   <= !in_buf;
      cmd.word_end   <= wend;
      cmd.list_end   <= list_end;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cas_queue.sv -----
// ----------------------------------------------------------------------------
// Custom alphabet sort check: command queue
// Short FIFO of letter commands between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_queue import cas_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cmd_t              push_cmd,
  input  logic              pop,
  output cmd_t              head,
  output logic [QCNT_W-1:0] count
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cas_back.sv -----
// ----------------------------------------------------------------------------
// Custom alphabet sort check: back end
// Resolves the order of each word pair letter by letter and buffers the
// per-list verdict in a two-entry result FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_back import cas_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_ready,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic pop,
  output logic empty,
  output logic sorted,
  output logic word_too_long
);

  typedef enum logic [1:0] {ST_EQUAL, ST_LESS, ST_GREATER} pair_status_t;

  pair_status_t pair_status;
  logic         out_of_order;
  logic         overflow_seen;

  pair_status_t status_next;
  logic         ooo_next;
  logic         ovf_next;

  logic       res_sorted [2];
  logic       res_long   [2];
  logic       res_wr;
  logic       res_rd;
  logic [1:0] res_count;
  logic       res_pop;

  assign cmd_pop = cmd_ready && !(cmd.list_end && res_count == 2'd2);
  assign res_pop = pop && !empty;
  assign empty   = res_count == 2'd0;
  assign sorted        = res_sorted[res_rd];
  assign word_too_long = res_long[res_rd];

  always_comb begin
    status_next = pair_status;
    ooo_next    = out_of_order;
    ovf_next    = overflow_seen | cmd.overflow;
    if (cmd.have_prev && pair_status == ST_EQUAL) begin
      if (!cmd.in_range) begin
        status_next = ST_LESS;   // previous word is a prefix of this one
      end else if (cmd.rank < cmd.prev_rank) begin
        status_next = ST_LESS;
      end else if (cmd.rank > cmd.prev_rank) begin
        status_next = ST_GREATER;
        ooo_next    = 1'b1;
      end
    end
    // this word is a proper prefix of the previous one
    if (cmd.word_end && cmd.have_prev && status_next == ST_EQUAL && cmd.short_word) begin
      ooo_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_status   <= ST_EQUAL;
      out_of_order  <= 1'b0;
      overflow_seen <= 1'b0;
      res_wr        <= 1'b0;
      res_rd        <= 1'b0;
      res_count     <= 2'd0;
    end else begin
      if (cmd_pop) begin
        priority if (cmd.list_end) begin
          pair_status   <= ST_EQUAL;
          out_of_order  <= 1'b0;
          overflow_seen <= 1'b0;
        end else if (cmd.word_end) begin
          pair_status   <= ST_EQUAL;
          out_of_order  <= ooo_next;
          overflow_seen <= ovf_next;
        end else begin
          pair_status   <= status_next;
          out_of_order  <= ooo_next;
          overflow_seen <= ovf_next;
        end
      end
      if (cmd_pop && cmd.list_end) begin
        res_wr <= ~res_wr;
      end
      if (res_pop) begin
        res_rd <= ~res_rd;
      end
      res_count <= res_count + 2'(cmd_pop && cmd.list_end) - 2'(res_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.list_end) begin
      res_sorted[res_wr] <= !ooo_next && !ovf_next;
      res_long[res_wr]   <= ovf_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/custom_alphabet_sort_check.sv -----
// ----------------------------------------------------------------------------
// Custom alphabet sort check
// Checks that a stream of words, one letter per transaction, is in
// non-decreasing order under a programmable 26-letter rank table.
//
//   channel   direction  handshake            payload
//   config    in         psel/penable/pready  paddr, pwdata, prdata
//   letters   in         push / full          letter, word_end, list_end
//   verdict   out        pop / empty          sorted, word_too_long
//
// One letter per cycle while the verdict FIFO has room; front end, queue and
// back end each take one letter per cycle, the front end with one rank buffer
// read and write. A list end is registered in the front end, then queued.
// Synchronous active-high reset; the rank buffer is not cleared.
// full rises only when the command queue backs up behind a full verdict FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

`include "custom_alphabet_sort_check_macros.svh"

module custom_alphabet_sort_check import cas_pkg::*; #(
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                push,
  output logic                full,
  input  logic [LETTER_W-1:0] letter,
  input  logic                word_end,
  input  logic                list_end,
  output logic                empty,
  input  logic                pop,
  output logic                sorted,
  output logic                word_too_long
);

  logic [LOW_W-1:0]  rank_table_low;
  logic [MID_W-1:0]  rank_table_mid;
  logic [HIGH_W-1:0] rank_table_high;

  logic [1:0]        reg_index;
  logic              cfg_write;
  logic              accept;
  logic              cmd_valid;
  cmd_t              cmd;
  cmd_t              head;
  logic [QCNT_W-1:0] q_count;
  logic              q_pop;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_table_low  <= RANK_LOW_RESET;
      rank_table_mid  <= RANK_MID_RESET;
      rank_table_high <= RANK_HIGH_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_RANK_LOW:  rank_table_low  <= pwdata[LOW_W-1:0];
        REG_RANK_MID:  rank_table_mid  <= pwdata[MID_W-1:0];
        REG_RANK_HIGH: rank_table_high <= pwdata[HIGH_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_RANK_LOW:  prdata = DATA_W'(rank_table_low);
      REG_RANK_MID:  prdata = DATA_W'(rank_table_mid);
      REG_RANK_HIGH: prdata = DATA_W'(rank_table_high);
      default:       prdata = '0;
    endcase
  end

  // room for the letter in flight plus the one being accepted
  assign full   = (q_count + QCNT_W'(cmd_valid)) >= QCNT_W'(QUEUE_DEPTH);
  assign accept = push && !full;

  cas_front #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .letter     (letter),
    .word_end   (word_end),
    .list_end   (list_end),
    .rank_table ({rank_table_high, rank_table_mid, rank_table_low}),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd)
  );

  cas_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_valid),
    .push_cmd (cmd),
    .pop      (q_pop),
    .head     (head),
    .count    (q_count)
  );

  cas_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_ready     (q_count != '0),
    .cmd           (head),
    .cmd_pop       (q_pop),
    .pop           (pop),
    .empty         (empty),
    .sorted        (sorted),
    .word_too_long (word_too_long)
  );

  `CAS_ASSERT_IMP(a_queue_bound, 1'b1, (q_count + QCNT_W'(cmd_valid)) <= QCNT_W'(QUEUE_DEPTH), "command queue overrun")
  `CAS_ASSERT_IMP(a_pop_nonempty, q_pop, q_count != '0, "back end popped an empty queue")
  `CAS_ASSERT_IMP(a_long_not_sorted, !empty && word_too_long, !sorted, "overlong word reported sorted")
  `CAS_ASSERT_NXT(a_accept_issues, accept, cmd_valid, "accepted letter issued no command")

endmodule

`default_nettype wire
